// ----- hw/rtl/hhsp_pkg.sv -----
package hhsp_pkg;

  typedef enum logic [2:0] {
    KIND_FIRST = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_EOH = 3'd2,
    KIND_BODY = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0,
    ERR_TOO_LONG = 4'd1,
    ERR_PREFIX = 4'd2,
    ERR_VERSION = 4'd3,
    ERR_STATUS = 4'd4,
    ERR_SPACE = 4'd5,
    ERR_NO_METHOD = 4'd6,
    ERR_NO_PATH = 4'd7,
    ERR_VER_CUT = 4'd8,
    ERR_CONTINUED = 4'd9,
    ERR_NO_COLON = 4'd10
  } err_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_HEADERS = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_OUT
  } state_e;

  localparam logic [7:0] ChCr = 8'h0d;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChSp = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChOne = 8'h31;
  localparam logic [7:0] ChTwo = 8'h32;
  localparam logic [7:0] ChNine = 8'h39;

  function automatic logic [7:0] prefix_char(input logic [2:0] i);
    logic [7:0] r;
    case (i)
      3'd0: r = 8'h48;
      3'd1: r = 8'h54;
      3'd2: r = 8'h54;
      3'd3: r = 8'h50;
      3'd4: r = 8'h2f;
      3'd5: r = 8'h31;
      3'd6: r = 8'h2e;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [2:0] kind;
    logic [31:0] line_start;
    logic [9:0] status_code;
    logic [1:0] version;
    logic [12:0] method_length;
    logic [12:0] path_length;
    logic [12:0] key_length;
    logic [12:0] value_offset;
    logic [12:0] value_length;
    logic [3:0] error_code;
  } result_t;

endpackage

// ----- hw/rtl/hhsp_line_mem.sv -----
module hhsp_line_mem #(
  parameter int Depth = 4096,
  parameter int AW = 12
) (
  input logic clk_i,
  input logic we_i,
  input logic [AW-1:0] waddr_i,
  input logic [7:0] wdata_i,
  input logic [AW-1:0] raddr_i,
  output logic [7:0] rdata_o
);
  logic [7:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hw/rtl/http1_header_stream_parser_top.sv -----
// Accepts one stream byte per request. Bytes of the header section are written
// to a line memory as they are taken; on the LF that ends a line, a scanner
// reads the stored line back one byte per cycle through the memory's single
// read port before another byte is taken. Body bytes are taken one per cycle
// when not stalled, each result showing the cycle after its request.
// A result waits in the output register while the output is stalled, and the
// input stalls with it; a new request is taken in the cycle the result leaves.
module http1_header_stream_parser_top
  import hhsp_pkg::*;
#(
  parameter int LINE_DEPTH = 4096
) (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic cfg_wdata_i,
  input logic in_valid_i,
  output logic in_stall_o,
  input logic [7:0] data_byte_i,
  output logic out_valid_o,
  input logic out_stall_i,
  output logic [2:0] kind_o,
  output logic [7:0] body_byte_o,
  output logic [31:0] line_start_o,
  output logic [9:0] status_code_o,
  output logic [1:0] version_o,
  output logic [12:0] method_length_o,
  output logic [12:0] path_length_o,
  output logic [12:0] key_length_o,
  output logic [12:0] value_offset_o,
  output logic [12:0] value_length_o,
  output logic [3:0] error_code_o
);
  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = AW + 1;
  localparam logic [FW-1:0] DepthF = FW'(LINE_DEPTH);

  logic msg_type_q;
  phase_e phase_q, phase_d;
  state_e state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic term1_q, term1_d;
  logic [31:0] pos_q, cls_q, cls_d;
  logic err_q, err_d;
  logic prev_cr_q, prev_cr_d;
  logic [FW-1:0] c_q, c_d;
  logic [3:0] step_q, step_d;
  logic [3:0] sub_q, sub_d;
  logic [FW-1:0] beg_q, beg_d;
  logic [7:0] major_q, major_d;
  logic [9:0] stat_q, stat_d;
  result_t res_q, res_d;
  logic [7:0] bb_q, bb_d;
  logic ov_q, ov_d;
  logic [3:0] perr_q, perr_d;

  logic accept;
  logic mem_we;
  logic [AW-1:0] raddr;
  logic [7:0] rd;
  logic [7:0] b;
  logic [FW-1:0] term;

  // Scan step codes.
  localparam logic [3:0] SMeth = 4'd0;
  localparam logic [3:0] SPath = 4'd1;
  localparam logic [3:0] SPfx = 4'd2;
  localparam logic [3:0] SMaj = 4'd3;
  localparam logic [3:0] SDot = 4'd4;
  localparam logic [3:0] SMin = 4'd5;
  localparam logic [3:0] RPfx = 4'd6;
  localparam logic [3:0] RVer = 4'd7;
  localparam logic [3:0] RSp1 = 4'd8;
  localparam logic [3:0] RStat = 4'd9;
  localparam logic [3:0] RSp2 = 4'd10;
  localparam logic [3:0] HKey = 4'd11;
  localparam logic [3:0] HBlank = 4'd12;

  assign in_stall_o = (state_q != ST_IDLE) || (ov_q && out_stall_i);
  assign accept = in_valid_i && !in_stall_o;
  assign mem_we = accept && !err_q && phase_q != PH_BODY && fill_q < DepthF;
  assign term = term1_q ? FW'(1) : FW'(2);
  assign b = rd;

  hhsp_line_mem #(.Depth(LINE_DEPTH), .AW(AW)) u_mem (
    .clk_i(clk_i),
    .we_i(mem_we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(data_byte_i),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_type_q <= 1'b0;
      phase_q <= PH_FIRST;
      state_q <= ST_IDLE;
      fill_q <= '0;
      term1_q <= 1'b0;
      pos_q <= '0;
      cls_q <= '0;
      err_q <= 1'b0;
      prev_cr_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        msg_type_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      state_q <= state_d;
      fill_q <= fill_d;
      term1_q <= term1_d;
      if (accept) begin
        pos_q <= pos_q + 32'd1;
      end
      cls_q <= cls_d;
      err_q <= err_d;
      prev_cr_q <= prev_cr_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    step_q <= step_d;
    sub_q <= sub_d;
    beg_q <= beg_d;
    major_q <= major_d;
    stat_q <= stat_d;
    res_q <= res_d;
    bb_q <= bb_d;
    perr_q <= perr_d;
  end

  // Read address: the scanner reads position c_d so data is ready next cycle.
  assign raddr = c_d[AW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !err_q && phase_q != PH_BODY && fill_q < DepthF &&
            data_byte_i == ChLf) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (perr_d != ERR_NONE || sub_d == 4'hf) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_OUT;
      ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    logic in_line;
    logic [FW-1:0] rest;
    phase_d = phase_q;
    fill_d = fill_q;
    term1_d = term1_q;
    cls_d = cls_q;
    err_d = err_q;
    prev_cr_d = prev_cr_q;
    c_d = c_q;
    step_d = step_q;
    sub_d = sub_q;
    beg_d = beg_q;
    major_d = major_q;
    stat_d = stat_q;
    res_d = res_q;
    bb_d = bb_q;
    ov_d = ov_q && out_stall_i;
    perr_d = perr_q;
    in_line = c_q < fill_q;
    rest = fill_q - c_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && !err_q) begin
          if (phase_q == PH_BODY) begin
            res_d = '0;
            res_d.kind = KIND_BODY;
            res_d.line_start = pos_q;
            bb_d = data_byte_i;
            ov_d = 1'b1;
          end else if (fill_q >= DepthF) begin
            res_d = '0;
            res_d.kind = KIND_ERROR;
            res_d.line_start = cls_q;
            res_d.error_code = ERR_TOO_LONG;
            bb_d = '0;
            ov_d = 1'b1;
            err_d = 1'b1;
          end else begin
            if (fill_q == '0) begin
              cls_d = pos_q;
            end
            fill_d = fill_q + FW'(1);
            prev_cr_d = data_byte_i == ChCr;
            if (data_byte_i == ChLf) begin
              if (!(fill_q >= FW'(1) && prev_cr_q)) begin
                term1_d = 1'b1;
              end
              res_d = '0;
              res_d.line_start = (fill_q == '0) ? pos_q : cls_q;
              bb_d = '0;
              perr_d = ERR_NONE;
              sub_d = '0;
              c_d = '0;
              stat_d = '0;
              if (phase_q == PH_FIRST) begin
                step_d = msg_type_q ? RPfx : SMeth;
              end else begin
                step_d = HKey;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        case (step_q)
          SMeth, SPath: begin
            if (!in_line) begin
              perr_d = (step_q == SMeth) ? ERR_NO_METHOD : ERR_NO_PATH;
            end else begin
              c_d = c_q + FW'(1);
              if (b == ChSp) begin
                if (c_d >= fill_q) begin
                  perr_d = (step_q == SMeth) ? ERR_NO_METHOD : ERR_NO_PATH;
                end else if (step_q == SMeth) begin
                  res_d.method_length = 13'(c_q);
                  beg_d = c_d;
                  step_d = SPath;
                end else begin
                  res_d.path_length = 13'(c_q - beg_q);
                  step_d = SPfx;
                  sub_d = '0;
                end
              end else if (c_d >= fill_q) begin
                perr_d = (step_q == SMeth) ? ERR_NO_METHOD : ERR_NO_PATH;
              end
            end
          end
          SPfx, RPfx: begin
            if (!in_line || b != prefix_char(sub_q[2:0])) begin
              perr_d = ERR_PREFIX;
            end else begin
              c_d = c_q + FW'(1);
              sub_d = sub_q + 4'd1;
              if (step_q == SPfx && sub_q == 4'd4) begin
                step_d = SMaj;
              end else if (step_q == RPfx && sub_q == 4'd6) begin
                step_d = RVer;
              end
            end
          end
          SMaj: begin
            if (!in_line || rest <= FW'(2)) begin
              perr_d = ERR_VER_CUT;
            end else begin
              major_d = b - ChZero;
              c_d = c_q + FW'(1);
              step_d = SDot;
            end
          end
          SDot: begin
            if (b != ChDot) begin
              perr_d = ERR_VERSION;
            end else begin
              c_d = c_q + FW'(1);
              step_d = SMin;
            end
          end
          SMin: begin
            if (major_q == 8'd1 && (b == ChZero || b == ChOne)) begin
              res_d.version = 2'(b - ChZero);
              sub_d = 4'hf;
            end else if (major_q == 8'd2 && b == ChZero) begin
              res_d.version = 2'd2;
              sub_d = 4'hf;
            end else begin
              perr_d = ERR_VERSION;
            end
          end
          RVer: begin
            if (!in_line || b < ChZero || b > ChOne) begin
              perr_d = ERR_VERSION;
            end else begin
              res_d.version = 2'(b - ChZero);
              c_d = c_q + FW'(1);
              step_d = RSp1;
            end
          end
          RSp1, RSp2: begin
            if (!in_line || b != ChSp) begin
              perr_d = ERR_SPACE;
            end else if (step_q == RSp1) begin
              c_d = c_q + FW'(1);
              step_d = RStat;
              sub_d = '0;
            end else begin
              sub_d = 4'hf;
            end
          end
          RStat: begin
            if (!in_line || b < ((sub_q == 4'd0) ? ChOne : ChZero) || b > ChNine) begin
              perr_d = ERR_STATUS;
            end else begin
              stat_d = 10'(stat_q * 10'd10) + 10'(b - ChZero);
              c_d = c_q + FW'(1);
              sub_d = sub_q + 4'd1;
              if (sub_q == 4'd2) begin
                res_d.status_code = stat_d;
                step_d = RSp2;
              end
            end
          end
          HKey: begin
            if (fill_q == term && c_q == '0) begin
              res_d.kind = KIND_EOH;
              sub_d = 4'hf;
            end else if (c_q == '0 && (b == ChSp || b == ChTab)) begin
              perr_d = ERR_CONTINUED;
            end else if (!in_line) begin
              perr_d = ERR_NO_COLON;
            end else if (b == ChColon) begin
              res_d.key_length = 13'(c_q);
              c_d = c_q + FW'(1);
              step_d = HBlank;
            end else begin
              c_d = c_q + FW'(1);
            end
          end
          HBlank: begin
            if (in_line && (b == ChSp || b == ChTab)) begin
              c_d = c_q + FW'(1);
            end else begin
              res_d.kind = KIND_HEADER;
              res_d.value_offset = 13'(c_q);
              res_d.value_length = (rest > term) ? 13'(rest - term) : 13'd0;
              sub_d = 4'hf;
            end
          end
          default: perr_d = ERR_PREFIX;
        endcase
      end
      ST_DONE: begin
        if (perr_q != ERR_NONE) begin
          res_d = '0;
          res_d.kind = KIND_ERROR;
          res_d.line_start = res_q.line_start;
          res_d.error_code = perr_q;
          err_d = 1'b1;
        end else begin
          fill_d = '0;
          if (phase_q == PH_FIRST) begin
            res_d.kind = KIND_FIRST;
            phase_d = PH_HEADERS;
          end else if (res_q.kind == KIND_EOH) begin
            phase_d = PH_BODY;
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign kind_o = res_q.kind;
  assign body_byte_o = bb_q;
  assign line_start_o = res_q.line_start;
  assign status_code_o = res_q.status_code;
  assign version_o = res_q.version;
  assign method_length_o = res_q.method_length;
  assign path_length_o = res_q.path_length;
  assign key_length_o = res_q.key_length;
  assign value_offset_o = res_q.value_offset;
  assign value_length_o = res_q.value_length;
  assign error_code_o = res_q.error_code;
endmodule

// ----- hw/rtl/hhsp_checker.sv -----
module hhsp_port_checker
  import hhsp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] body_byte_o,
  input logic [3:0] error_code_o
);
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o <= KIND_ERROR)) else $error("kind out of range");

  a_err_only_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_ERROR) |-> (error_code_o == ERR_NONE))
    else $error("error code on a non-error result");

  a_body_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_BODY) |-> (body_byte_o == 8'd0))
    else $error("body byte on a non-body result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o)))
    else $error("stalled result changed");
endmodule

bind http1_header_stream_parser_top hhsp_port_checker u_hhsp_port_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .kind_o(kind_o),
  .body_byte_o(body_byte_o),
  .error_code_o(error_code_o)
);

// ----- tb/sv/hhsp_checker.sv -----
module hhsp_checker
  import hhsp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic cfg_wdata_i,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic [7:0] data_byte_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [2:0] kind_o,
  input logic [7:0] body_byte_o,
  input logic [31:0] line_start_o,
  input logic [9:0] status_code_o,
  input logic [1:0] version_o,
  input logic [12:0] method_length_o,
  input logic [12:0] path_length_o,
  input logic [12:0] key_length_o,
  input logic [12:0] value_offset_o,
  input logic [12:0] value_length_o,
  input logic [3:0] error_code_o,
  output int fail_count,
  output int pending,
  output int results_seen
);

  localparam int LineDepth = 4096;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body;
    logic [31:0] start;
    logic [9:0] status;
    logic [1:0] ver;
    logic [12:0] meth;
    logic [12:0] path;
    logic [12:0] key;
    logic [12:0] voff;
    logic [12:0] vlen;
    logic [3:0] err;
  } parse_rec_t;

  logic [7:0] http_tag [7] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e};

  logic msg_is_resp;
  phase_e ph;
  logic [7:0] line_mem [LineDepth];
  int fill;
  bit lf_only;
  logic [31:0] stream_pos;
  logic [31:0] cur_start;
  bit dead;
  parse_rec_t expected_q [$];
  parse_rec_t want;
  parse_rec_t got;
  bit has_rec;

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    msg_is_resp = 0;
    ph = PH_FIRST;
    fill = 0;
    lf_only = 0;
    stream_pos = 0;
    cur_start = 0;
    dead = 0;
  end

  function automatic logic [7:0] line_at(int i);
    return (i < fill) ? line_mem[i] : 8'h00;
  endfunction

  function automatic int skip_word(int c);
    logic [7:0] b;
    while (c < fill) begin
      b = line_at(c);
      c++;
      if (b == ChSp) break;
    end
    return c;
  endfunction

  function automatic err_e parse_req(inout parse_rec_t r);
    int c;
    int beg;
    logic [7:0] major;
    logic [7:0] minor;
    c = skip_word(0);
    if (c >= fill) return ERR_NO_METHOD;
    r.meth = 13'(c - 1);
    beg = c;
    c = skip_word(c);
    if (c >= fill) return ERR_NO_PATH;
    r.path = 13'(c - beg - 1);
    for (int i = 0; i < 5; i++) begin
      if (c >= fill || line_at(c) != http_tag[i]) return ERR_PREFIX;
      c++;
    end
    if (c >= fill) return ERR_VER_CUT;
    major = line_at(c) - ChZero;
    if (fill - c <= 2) return ERR_VER_CUT;
    if (line_at(c + 1) != ChDot) return ERR_VERSION;
    minor = line_at(c + 2) - ChZero;
    if (major == 1 && minor <= 1) r.ver = minor[1:0];
    else if (major == 2 && minor == 0) r.ver = 2'd2;
    else return ERR_VERSION;
    return ERR_NONE;
  endfunction

  function automatic err_e parse_resp(inout parse_rec_t r);
    int c;
    logic [7:0] b;
    int code;
    c = 0;
    code = 0;
    for (int i = 0; i < 7; i++) begin
      if (c >= fill || line_at(c) != http_tag[i]) return ERR_PREFIX;
      c++;
    end
    b = line_at(c);
    if (c >= fill || b < ChZero || b > ChOne) return ERR_VERSION;
    r.ver = 2'(b - ChZero);
    c++;
    if (c >= fill || line_at(c) != ChSp) return ERR_SPACE;
    c++;
    for (int i = 0; i < 3; i++) begin
      b = line_at(c);
      if (c >= fill || b < ((i == 0) ? ChOne : ChZero) || b > ChNine) return ERR_STATUS;
      code = code * 10 + (b - ChZero);
      c++;
    end
    r.status = 10'(code);
    if (c >= fill || line_at(c) != ChSp) return ERR_SPACE;
    return ERR_NONE;
  endfunction

  function automatic err_e parse_hdr(inout parse_rec_t r, input int tl);
    int c;
    int rest;
    logic [7:0] b;
    c = 0;
    b = line_at(0);
    if (b == ChSp || b == ChTab) return ERR_CONTINUED;
    while (c < fill && line_at(c) != ChColon) c++;
    if (c >= fill) return ERR_NO_COLON;
    r.key = 13'(c);
    c++;
    while (c < fill && (line_at(c) == ChSp || line_at(c) == ChTab)) c++;
    r.voff = 13'(c);
    rest = fill - c;
    r.vlen = (rest > tl) ? 13'(rest - tl) : 13'd0;
    return ERR_NONE;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, output bit has,
                                       output parse_rec_t r);
    logic [31:0] p;
    logic [31:0] s;
    err_e e;
    int tl;
    has = 0;
    r = '0;
    e = ERR_NONE;
    p = stream_pos;
    stream_pos = stream_pos + 32'd1;
    if (dead) return;
    if (ph == PH_BODY) begin
      has = 1;
      r.kind = KIND_BODY;
      r.body = b;
      r.start = p;
      return;
    end
    if (fill >= LineDepth) begin
      e = ERR_TOO_LONG;
      r.start = cur_start;
    end else begin
      if (fill == 0) cur_start = p;
      line_mem[fill] = b;
      fill++;
      if (b != ChLf) return;
      if (!(fill >= 2 && line_mem[fill - 2] == ChCr)) lf_only = 1;
      r.start = cur_start;
      if (ph == PH_FIRST) begin
        e = msg_is_resp ? parse_resp(r) : parse_req(r);
        if (e == ERR_NONE) begin
          r.kind = KIND_FIRST;
          ph = PH_HEADERS;
        end
      end else begin
        tl = lf_only ? 1 : 2;
        if (fill == tl) begin
          r.kind = KIND_EOH;
          ph = PH_BODY;
        end else begin
          e = parse_hdr(r, tl);
          if (e == ERR_NONE) r.kind = KIND_HEADER;
        end
      end
      if (e == ERR_NONE) fill = 0;
    end
    if (e != ERR_NONE) begin
      s = r.start;
      r = '0;
      r.kind = KIND_ERROR;
      r.start = s;
      r.err = e;
      dead = 1;
    end
    has = 1;
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) msg_is_resp = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        predict_byte(data_byte_i, has_rec, want);
        if (has_rec) expected_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: kind %0d", kind_o);
          fail_count++;
        end else begin
          got = expected_q.pop_front();
          check_field("kind", 32'(got.kind), 32'(kind_o));
          check_field("body_byte", 32'(got.body), 32'(body_byte_o));
          check_field("line_start", got.start, line_start_o);
          check_field("status_code", 32'(got.status), 32'(status_code_o));
          check_field("version", 32'(got.ver), 32'(version_o));
          check_field("method_length", 32'(got.meth), 32'(method_length_o));
          check_field("path_length", 32'(got.path), 32'(path_length_o));
          check_field("key_length", 32'(got.key), 32'(key_length_o));
          check_field("value_offset", 32'(got.voff), 32'(value_offset_o));
          check_field("value_length", 32'(got.vlen), 32'(value_length_o));
          check_field("error_code", 32'(got.err), 32'(error_code_o));
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_http1_header_stream_parser_top.sv -----
module tb_http1_header_stream_parser_top;
  import hhsp_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [7:0] data_byte = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] kind;
  logic [7:0] body_byte;
  logic [31:0] line_start;
  logic [9:0] status_code;
  logic [1:0] version;
  logic [12:0] method_length;
  logic [12:0] path_length;
  logic [12:0] key_length;
  logic [12:0] value_offset;
  logic [12:0] value_length;
  logic [3:0] error_code;

  int fail_count;
  int pending;
  int results_seen;
  int bytes_sent = 0;
  int cycles = 0;
  bit calm = 0;
  bit hold_req = 0;
  bit resp_mode;
  string ending;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  http1_header_stream_parser_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .kind_o(kind),
    .body_byte_o(body_byte), .line_start_o(line_start), .status_code_o(status_code),
    .version_o(version), .method_length_o(method_length), .path_length_o(path_length),
    .key_length_o(key_length), .value_offset_o(value_offset),
    .value_length_o(value_length), .error_code_o(error_code)
  );

  hhsp_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .kind_o(kind),
    .body_byte_o(body_byte), .line_start_o(line_start), .status_code_o(status_code),
    .version_o(version), .method_length_o(method_length), .path_length_o(path_length),
    .key_length_o(key_length), .value_offset_o(value_offset),
    .value_length_o(value_length), .error_code_o(error_code),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_http1_header_stream_parser_top: FAIL");
      $finish;
    end
  end

  // The receiver holds off for a drawn number of cycles before each result.
  initial begin
    int n;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) n = 3000;
      else if (calm) n = 0;
      else n = $urandom_range(0, 12);
      hold_req = 0;
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int g;
    in_valid <= 1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    g = calm ? 0 : $urandom_range(0, 12);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_eol();
    if ($urandom_range(0, 15) == 0) send_byte(ChLf);
    else send_str("\r\n");
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_word(input int n);
    for (int i = 0; i < n; i++) send_byte(8'(8'h61 + $urandom_range(0, 25)));
  endtask

  task automatic send_first_line();
    int sel;
    if (resp_mode) begin
      send_str("HTTP/1.");
      send_byte(8'(ChZero + $urandom_range(0, 1)));
      send_byte(ChSp);
      send_byte(8'(ChOne + $urandom_range(0, 8)));
      send_byte(8'(ChZero + $urandom_range(0, 9)));
      send_byte(8'(ChZero + $urandom_range(0, 9)));
      send_byte(ChSp);
      send_word($urandom_range(0, 6));
    end else begin
      send_word($urandom_range(0, 6));
      send_byte(ChSp);
      send_byte(8'h2f);
      send_word($urandom_range(0, 10));
      sel = $urandom_range(0, 2);
      send_str(sel == 0 ? " HTTP/1.0" : (sel == 1 ? " HTTP/1.1" : " HTTP/2.0"));
      if ($urandom_range(0, 1)) send_str(" extra");
    end
    send_eol();
  endtask

  task automatic send_header();
    int v;
    send_word($urandom_range(0, 8));
    send_byte(ChColon);
    repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? ChSp : ChTab);
    repeat ($urandom_range(0, 20)) begin
      v = $urandom_range(0, 255);
      if (v == ChLf) v = 8'h0b;
      send_byte(8'(v));
    end
    send_eol();
  endtask

  initial begin
    int sel;
    bit held;
    bit paused;
    held = 0;
    paused = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    resp_mode = 1'($urandom_range(0, 1));
    write_cfg(resp_mode);

    send_first_line();
    drain();
    write_cfg(!resp_mode);

    send_str("Host: a\r\n");
    send_str(":v\r\n");
    send_str("K:\t \r\n");
    send_str("X: ");
    send_byte(8'hff);
    send_byte(8'h80);
    send_str("\r\n");

    while (bytes_sent < 850) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      if (!held && bytes_sent > 300) begin
        held = 1;
        hold_req = 1;
      end
      if (!paused && bytes_sent > 600) begin
        paused = 1;
        drain();
        write_cfg(1'($urandom_range(0, 1)));
      end
      send_header();
    end
    calm = 0;

    sel = $urandom_range(0, 4);
    if (sel <= 2) begin
      ending = "end of headers and body";
      if ($urandom_range(0, 1)) send_byte(ChLf);
      else send_str("\r\n");
      repeat (250) begin
        if ($urandom_range(0, 15) == 0) calm = !calm;
        send_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      if (sel == 3) begin
        ending = "header without colon";
        send_str("abc\r\n");
      end else begin
        ending = "continued header";
        send_str(" a:b\r\n");
      end
      repeat (250) send_byte(8'($urandom_range(0, 255)));
    end
    drain();

    $display("Sent %0d bytes as a %s, checked %0d results, ending with %s.",
             bytes_sent, resp_mode ? "response" : "request", results_seen, ending);
    if (fail_count == 0) begin
      $display("tb_http1_header_stream_parser_top: PASS");
    end else begin
      $display("tb_http1_header_stream_parser_top: FAIL");
    end
    $finish;
  end

endmodule
